// ===== src/greedy_min_cost_pairing_macros.svh =====
// assertion macros used by the checker file
`ifndef GREEDY_MIN_COST_PAIRING_MACROS_SVH
`define GREEDY_MIN_COST_PAIRING_MACROS_SVH

// same-cycle implication, sampled on clk and masked during reset
`define GMCP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gmcp assertion failed");

// next-cycle implication, sampled on clk and masked during reset
`define GMCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmcp assertion failed");

`endif

// ===== src/gmcp_pkg.sv =====
// package with shared types and constants for the greedy pairing block
`timescale 1ns / 1ps

package gmcp_pkg;

	localparam int GMCP_MAX_UNITS = 16;
	localparam int GMCP_COST_BITS = 32;

	localparam int UNIT_W      = 4;
	localparam int COUNT_W     = 5;
	localparam int IN_COST_W   = 32;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 8;

	localparam logic [COUNT_W-1:0] UNIT_COUNT_RST = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT,
		ST_LEFT
	} gmcp_state_t;

	typedef struct packed {
		logic load_wr;
		logic run_init;
		logic scan_step;
		logic emit_pair;
		logic left_step;
		logic emit_left;
	} gmcp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic scan_last;
		logic last_round;
		logic odd;
		logic left_hit;
		logic out_free;
	} gmcp_sts_t;

endpackage

// ===== src/gmcp_ctrl.sv =====
// controller state machine sequencing load, scan, emit and leftover search
`timescale 1ns / 1ps

module gmcp_ctrl
	import gmcp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  gmcp_sts_t sts,
	output gmcp_cmd_t cmd
);

	gmcp_state_t state_q;
	gmcp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (in_last) begin
						cmd.run_init = 1'b1;
						if (sts.cnt_zero) begin
							state_d = ST_IDLE;
						end else if (sts.cnt_one) begin
							state_d = ST_LEFT;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_pair = 1'b1;
					if (sts.last_round) begin
						state_d = sts.odd ? ST_LEFT : ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_LEFT: begin
				if (sts.left_hit) begin
					if (sts.out_free) begin
						cmd.emit_left = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.left_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/gmcp_datapath.sv =====
// datapath with cost memory, scan counters, minimum tracking and result register
`timescale 1ns / 1ps

module gmcp_datapath
	import gmcp_pkg::*;
#(
	parameter int MAX_UNITS = GMCP_MAX_UNITS,
	parameter int COST_BITS = GMCP_COST_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gmcp_cmd_t            cmd,
	output gmcp_sts_t            sts,
	input  logic                 cfg_valid,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic [UNIT_W-1:0]    in_row,
	input  logic [UNIT_W-1:0]    in_col,
	input  logic [IN_COST_W-1:0] in_cost,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [UNIT_W-1:0]    out_first,
	output logic [UNIT_W-1:0]    out_second,
	output logic                 out_partner,
	output logic                 out_last
);

	localparam int IDX_W  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int CNT_W  = $clog2(MAX_UNITS + 1);
	localparam int DEPTH  = MAX_UNITS * MAX_UNITS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [COST_BITS-1:0] mem [DEPTH];

	logic [COUNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     pairs_done_q;
	logic [CNT_W-1:0]     rounds;
	logic [IDX_W-1:0]     last_idx;
	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     j_q;
	logic [MAX_UNITS-1:0] used_q;
	logic                 candidate;
	logic                 row_ok;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;

	logic                 cand_s1;
	logic [IDX_W-1:0]     i_s1;
	logic [IDX_W-1:0]     j_s1;
	logic [COST_BITS-1:0] rd_data_s1;

	logic                 found_q;
	logic [COST_BITS-1:0] best_q;
	logic [IDX_W-1:0]     bi_q;
	logic [IDX_W-1:0]     bj_q;

	logic                 out_valid_q;
	logic [UNIT_W-1:0]    out_first_q;
	logic [UNIT_W-1:0]    out_second_q;
	logic                 out_partner_q;
	logic                 out_last_q;

	// unit count saturates at the store size
	assign n_eff = ({{(32-COUNT_W){1'b0}}, cnt_q} > 32'(MAX_UNITS)) ?
		CNT_W'(MAX_UNITS) : CNT_W'(cnt_q);

	assign rounds   = n_q >> 1;
	assign last_idx = IDX_W'(n_q - CNT_W'(1));

	assign row_ok  = (32'(in_row) < 32'(MAX_UNITS)) && (32'(in_col) < 32'(MAX_UNITS));
	assign wr_addr = ADDR_W'(IDX_W'(in_row)) * ADDR_W'(MAX_UNITS) + ADDR_W'(IDX_W'(in_col));
	assign rd_addr = ADDR_W'(i_q) * ADDR_W'(MAX_UNITS) + ADDR_W'(j_q);

	assign candidate = (i_q != j_q) && !used_q[i_q] && !used_q[j_q];

	always_comb begin
		sts            = '0;
		sts.cnt_zero   = (n_eff == '0);
		sts.cnt_one    = (n_eff == CNT_W'(1));
		sts.scan_last  = (i_q == last_idx) && (j_q == last_idx);
		sts.last_round = ((pairs_done_q + CNT_W'(1)) == rounds);
		sts.odd        = n_q[0];
		sts.left_hit   = !used_q[i_q];
		sts.out_free   = !out_valid_q || out_ready;
	end

	// unit count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= UNIT_COUNT_RST;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// cost memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.load_wr && row_ok) begin
			mem[wr_addr] <= COST_BITS'(in_cost);
		end
		if (cmd.scan_step) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
	end

	// run control and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			pairs_done_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			used_q       <= '0;
			cand_s1      <= 1'b0;
		end else begin
			cand_s1 <= cmd.scan_step && candidate;
			if (cmd.run_init) begin
				n_q          <= n_eff;
				pairs_done_q <= '0;
				i_q          <= '0;
				j_q          <= '0;
				used_q       <= '0;
			end else if (cmd.emit_pair) begin
				pairs_done_q <= pairs_done_q + CNT_W'(1);
				i_q          <= '0;
				j_q          <= '0;
				used_q       <= used_q | (MAX_UNITS'(1) << bi_q) | (MAX_UNITS'(1) << bj_q);
			end else if (cmd.scan_step) begin
				if (j_q == last_idx) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else if (cmd.left_step) begin
				i_q <= i_q + IDX_W'(1);
			end
		end
	end

	// running minimum, strict compare keeps the first pair on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.run_init || cmd.emit_pair) begin
			found_q <= 1'b0;
		end else if (cand_s1 && (!found_q || (rd_data_s1 < best_q))) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_s1 && (!found_q || (rd_data_s1 < best_q))) begin
			best_q <= rd_data_s1;
			bi_q   <= i_s1;
			bj_q   <= j_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pair || cmd.emit_left) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pair) begin
			out_first_q   <= UNIT_W'(bi_q);
			out_second_q  <= UNIT_W'(bj_q);
			out_partner_q <= 1'b1;
			out_last_q    <= sts.last_round && !sts.odd;
		end else if (cmd.emit_left) begin
			out_first_q   <= UNIT_W'(i_q);
			out_second_q  <= '0;
			out_partner_q <= 1'b0;
			out_last_q    <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_first   = out_first_q;
	assign out_second  = out_second_q;
	assign out_partner = out_partner_q;
	assign out_last    = out_last_q;

endmodule

// ===== src/greedy_min_cost_pairing.sv =====
// load: one cost entry per cycle while idle; the entry with tlast starts a run
// each pair scans all n*n ordered pairs through the single cost memory read port, then drains and emits
// the leftover unit of an odd count is found by stepping through the units, then emitted once the output is free
// a run blocks the input until its final result is loaded into the output register
// reset clears control and used marks and sets the unit count to 16; the cost memory keeps no reset value
`timescale 1ns / 1ps

module greedy_min_cost_pairing
	import gmcp_pkg::*;
#(
	parameter int MAX_UNITS = GMCP_MAX_UNITS,
	parameter int COST_BITS = GMCP_COST_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data,      // unit_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row, col, cost
	input  logic                  s_axis_tlast,  // start_run
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // first_unit, second_unit
	output logic                  m_axis_tuser,  // has_partner
	output logic                  m_axis_tlast   // last_pair
);

	gmcp_cmd_t         cmd;
	gmcp_sts_t         sts;
	logic [UNIT_W-1:0] out_first;
	logic [UNIT_W-1:0] out_second;

	assign cfg_ready = 1'b1;

	gmcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gmcp_datapath #(
		.MAX_UNITS (MAX_UNITS),
		.COST_BITS (COST_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_row      (s_axis_tdata[3:0]),
		.in_col      (s_axis_tdata[7:4]),
		.in_cost     (s_axis_tdata[39:8]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_first   (out_first),
		.out_second  (out_second),
		.out_partner (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {out_second, out_first};

endmodule

// ===== src/gmcp_checker.sv =====
// port-level checker for the greedy pairing block, bound to the top level
`timescale 1ns / 1ps
`include "greedy_min_cost_pairing_macros.svh"

module gmcp_checker
	import gmcp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser,
	input logic                  m_axis_tlast
);

	`GMCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`GMCP_ASSERT_IMPL(a_left_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
	`GMCP_ASSERT_IMPL(a_left_no_second, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:4] == 4'd0)
	`GMCP_ASSERT_IMPL(a_pair_distinct, m_axis_tvalid && m_axis_tuser, m_axis_tdata[3:0] != m_axis_tdata[7:4])

endmodule

bind greedy_min_cost_pairing gmcp_checker u_gmcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/greedy_min_cost_pairing_test.sv =====
`timescale 1ns / 1ps
// stream testbench for the greedy pairing block: directed table, then random runs checked by a predictor

module greedy_min_cost_pairing_test;
	import gmcp_pkg::*;

	localparam int UNITS     = GMCP_MAX_UNITS;
	localparam int DIR_LEN   = 24;
	localparam int ITEM_GOAL = 280;
	localparam int PAIR_GOAL = 60;
	localparam int SETTLE    = 40;

	typedef struct packed {
		logic [UNIT_W-1:0] first_unit;
		logic [UNIT_W-1:0] second_unit;
		logic              has_partner;
		logic              last_pair;
	} pair_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} check_t;

	typedef enum logic {
		DIR_CFG,
		DIR_LOAD
	} dir_op_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} stall_t;

	typedef struct {
		dir_op_t              op;
		logic [COUNT_W-1:0]   units;
		logic [UNIT_W-1:0]    row;
		logic [UNIT_W-1:0]    col;
		logic [IN_COST_W-1:0] cost;
		logic                 start;
		check_t               chk;
		pair_t                want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	logic [IN_COST_W-1:0] cost_mem [UNITS*UNITS];
	bit                   loaded [UNITS*UNITS];
	logic [COUNT_W-1:0]   units_cfg = UNIT_COUNT_RST;
	pair_t                pairs_due [$];
	dir_row_t             dir_tab [DIR_LEN];
	int                   errors = 0;
	int                   items_sent = 0;
	int                   pairs_seen = 0;
	int                   burst_left = 0;
	stall_t               stall_mode = RX_OPEN;
	int                   stall_left = 0;
	int                   stall_tick = 0;

	greedy_min_cost_pairing uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int active_units();
		return (units_cfg > UNITS) ? UNITS : int'(units_cfg);
	endfunction

	// greedy pairing over the loaded costs, appends the results of one run
	function automatic void predict_run();
		int n, rounds, total, cnt, i, j, k, bi, bj;
		bit taken [UNITS];
		bit found;
		logic [IN_COST_W-1:0] best;
		pair_t p;
		n = active_units();
		rounds = n / 2;
		total = rounds + n % 2;
		cnt = 0;
		for (i = 0; i < UNITS; i++)
			taken[i] = 1'b0;
		for (k = 0; k < rounds; k++) begin
			found = 1'b0;
			best = '0;
			bi = 0;
			bj = 0;
			for (i = 0; i < n; i++) begin
				for (j = 0; j < n; j++) begin
					if (i != j && !taken[i] && !taken[j]) begin
						if (!found || cost_mem[i*UNITS+j] < best) begin
							found = 1'b1;
							best = cost_mem[i*UNITS+j];
							bi = i;
							bj = j;
						end
					end
				end
			end
			taken[bi] = 1'b1;
			taken[bj] = 1'b1;
			p.first_unit = UNIT_W'(bi);
			p.second_unit = UNIT_W'(bj);
			p.has_partner = 1'b1;
			p.last_pair = (cnt + 1 == total);
			pairs_due = {pairs_due, p};
			cnt++;
		end
		if (n % 2 == 1) begin
			bi = 0;
			for (i = n - 1; i >= 0; i--)
				if (!taken[i])
					bi = i;
			p.first_unit = UNIT_W'(bi);
			p.second_unit = '0;
			p.has_partner = 1'b0;
			p.last_pair = 1'b1;
			pairs_due = {pairs_due, p};
		end
	endfunction

	function automatic logic [IN_COST_W-1:0] pick_cost();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return IN_COST_W'($urandom_range(0, 3));
			3: return IN_COST_W'($urandom_range(0, 15)) << 28;
			default: return $urandom;
		endcase
	endfunction

	// bursts of transactions with random idle gaps, sometimes none, between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	task automatic load_entry(input logic [UNIT_W-1:0] row, input logic [UNIT_W-1:0] col,
			input logic [IN_COST_W-1:0] cost, input logic start, input check_t chk,
			input pair_t want);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {cost, col, row};
		s_axis_tlast <= start;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		cost_mem[{row, col}] = cost;
		loaded[{row, col}] = 1'b1;
		if (start) begin
			case (chk)
				CHK_MODEL: predict_run();
				CHK_ONE: pairs_due = {pairs_due, want};
				default: ;
			endcase
		end
	endtask

	// only while idle: drain all results, let the block settle, then write
	task automatic write_units(input logic [COUNT_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pairs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		units_cfg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		burst_left = 0;
	endtask

	// every off-diagonal entry a run will read must hold a written cost
	task automatic fill_entries();
		int n, i, j;
		n = active_units();
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				if (i != j && !loaded[i*UNITS+j]) begin
					pace_sender();
					load_entry(UNIT_W'(i), UNIT_W'(j), pick_cost(), 1'b0, CHK_MODEL, '0);
				end
			end
		end
	endtask

	task automatic random_run();
		int n, k, loads;
		logic [UNIT_W-1:0] r, c;
		n = active_units();
		loads = $urandom_range(0, 6);
		for (k = 0; k < loads; k++) begin
			if (n > 0 && $urandom_range(0, 3) != 0) begin
				r = UNIT_W'($urandom_range(0, n - 1));
				c = UNIT_W'($urandom_range(0, n - 1));
			end else begin
				r = UNIT_W'($urandom);
				c = UNIT_W'($urandom);
			end
			pace_sender();
			load_entry(r, c, pick_cost(), 1'b0, CHK_MODEL, '0);
		end
		fill_entries();
		if ($urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			while (pairs_due.size() != 0) @(posedge clk);
		end
		pace_sender();
		load_entry(UNIT_W'($urandom), UNIT_W'($urandom), pick_cost(), 1'b1, CHK_MODEL, '0);
	endtask

	task automatic random_phase(input logic [COUNT_W-1:0] value);
		write_units(value);
		repeat ($urandom_range(1, 3)) random_run();
	endtask

	// receiver stall pattern: open, coin toss, sparse or periodic, picked anew at random
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (stall_tick % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		pair_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.first_unit = m_axis_tdata[UNIT_W-1:0];
			got.second_unit = m_axis_tdata[2*UNIT_W-1:UNIT_W];
			got.has_partner = m_axis_tuser;
			got.last_pair = m_axis_tlast;
			if (pairs_due.size() == 0) begin
				$display("%0t: result with none expected, actual first=%0d second=%0d",
					$time, got.first_unit, got.second_unit,
					" partner=%0b last=%0b", got.has_partner, got.last_pair);
				errors++;
			end else begin
				want = pairs_due.pop_front();
				pairs_seen++;
				if (got !== want) begin
					$display("%0t: expected first=%0d second=%0d partner=%0b last=%0b",
						$time, want.first_unit, want.second_unit, want.has_partner,
						want.last_pair, ", actual first=%0d second=%0d partner=%0b last=%0b",
						got.first_unit, got.second_unit, got.has_partner, got.last_pair);
					errors++;
				end
			end
		end
	end

	initial begin
		int idx;
		logic [COUNT_W-1:0] pick;
		dir_tab[0]  = '{DIR_CFG,  5'd1, 4'd0,  4'd0, 32'd0,          1'b0, CHK_NONE,  '0};
		dir_tab[1]  = '{DIR_LOAD, 5'd0, 4'd0,  4'd0, 32'd0,          1'b1, CHK_ONE,
			'{4'd0, 4'd0, 1'b0, 1'b1}};
		dir_tab[2]  = '{DIR_CFG,  5'd0, 4'd0,  4'd0, 32'd0,          1'b0, CHK_NONE,  '0};
		dir_tab[3]  = '{DIR_LOAD, 5'd0, 4'd5,  4'd9, 32'hFFFF_FFFF,  1'b1, CHK_NONE,  '0};
		dir_tab[4]  = '{DIR_CFG,  5'd2, 4'd0,  4'd0, 32'd0,          1'b0, CHK_NONE,  '0};
		dir_tab[5]  = '{DIR_LOAD, 5'd0, 4'd0,  4'd1, 32'hFFFF_FFFF,  1'b0, CHK_MODEL, '0};
		dir_tab[6]  = '{DIR_LOAD, 5'd0, 4'd1,  4'd0, 32'hFFFF_FFFF,  1'b1, CHK_ONE,
			'{4'd0, 4'd1, 1'b1, 1'b1}};
		dir_tab[7]  = '{DIR_LOAD, 5'd0, 4'd1,  4'd0, 32'hFFFF_FFFE,  1'b1, CHK_ONE,
			'{4'd1, 4'd0, 1'b1, 1'b1}};
		dir_tab[8]  = '{DIR_LOAD, 5'd0, 4'd0,  4'd1, 32'd0,          1'b1, CHK_ONE,
			'{4'd0, 4'd1, 1'b1, 1'b1}};
		dir_tab[9]  = '{DIR_CFG,  5'd3, 4'd0,  4'd0, 32'd0,          1'b0, CHK_NONE,  '0};
		dir_tab[10] = '{DIR_LOAD, 5'd0, 4'd0,  4'd2, 32'd5,          1'b0, CHK_MODEL, '0};
		dir_tab[11] = '{DIR_LOAD, 5'd0, 4'd2,  4'd0, 32'd5,          1'b0, CHK_MODEL, '0};
		dir_tab[12] = '{DIR_LOAD, 5'd0, 4'd1,  4'd2, 32'd0,          1'b0, CHK_MODEL, '0};
		dir_tab[13] = '{DIR_LOAD, 5'd0, 4'd2,  4'd1, 32'd7,          1'b1, CHK_MODEL, '0};
		dir_tab[14] = '{DIR_LOAD, 5'd0, 4'd2,  4'd2, 32'd0,          1'b1, CHK_MODEL, '0};
		dir_tab[15] = '{DIR_CFG,  5'd4, 4'd0,  4'd0, 32'd0,          1'b0, CHK_NONE,  '0};
		dir_tab[16] = '{DIR_LOAD, 5'd0, 4'd0,  4'd3, 32'hFFFF_FFFF,  1'b0, CHK_MODEL, '0};
		dir_tab[17] = '{DIR_LOAD, 5'd0, 4'd3,  4'd0, 32'd1,          1'b0, CHK_MODEL, '0};
		dir_tab[18] = '{DIR_LOAD, 5'd0, 4'd1,  4'd3, 32'd3,          1'b0, CHK_MODEL, '0};
		dir_tab[19] = '{DIR_LOAD, 5'd0, 4'd2,  4'd3, 32'd3,          1'b0, CHK_MODEL, '0};
		dir_tab[20] = '{DIR_LOAD, 5'd0, 4'd3,  4'd1, 32'd0,          1'b0, CHK_MODEL, '0};
		dir_tab[21] = '{DIR_LOAD, 5'd0, 4'd3,  4'd2, 32'hFFFF_FFFF,  1'b1, CHK_MODEL, '0};
		dir_tab[22] = '{DIR_LOAD, 5'd0, 4'd15, 4'd15, 32'd0,         1'b0, CHK_MODEL, '0};
		dir_tab[23] = '{DIR_LOAD, 5'd0, 4'd15, 4'd0, 32'hA5A5_A5A5,  1'b1, CHK_MODEL, '0};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (idx = 0; idx < DIR_LEN; idx++) begin
			if (dir_tab[idx].op == DIR_CFG) begin
				write_units(dir_tab[idx].units);
			end else begin
				pace_sender();
				load_entry(dir_tab[idx].row, dir_tab[idx].col, dir_tab[idx].cost,
					dir_tab[idx].start, dir_tab[idx].chk, dir_tab[idx].want);
			end
		end

		// full matrix first, so later runs of any size read only written costs
		random_phase(5'd16);
		while (items_sent < ITEM_GOAL || pairs_seen < PAIR_GOAL) begin
			case ($urandom_range(0, 9))
				0: pick = COUNT_W'($urandom_range(17, 31));
				1: pick = 5'd16;
				2: pick = COUNT_W'($urandom_range(0, 1));
				default: pick = COUNT_W'($urandom_range(2, 9));
			endcase
			random_phase(pick);
		end
		random_phase(5'd31);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pairs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
